>>> rtl/palette_slot_allocator_unit_assert.svh
// Assertion macros used by the palette slot allocator unit.
// They rely on clk and arst_n being visible in the scope of use.
`ifndef PALETTE_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define PALETTE_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define PSA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define PSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/psa_pkg.sv
package psa_pkg;

	// Widths fixed by the beat formats
	localparam int RGB_W    = 24;
	localparam int CIDX_W   = 8;
	localparam int SLOTS_W  = 9;
	localparam int LIMIT_W  = 9;
	localparam int STAT_W   = 3;
	localparam int CFG_IX_W = 2;
	localparam int PRESET_N = 8;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_MATCHED   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_ALLOCATED = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] STAT_BW        = 3'd3;
	localparam logic [STAT_W-1:0] STAT_RESTARTED = 3'd4;

	// Operation codes
	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IX_W-1:0] CFG_TABLE_LIMIT   = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_WHITE_CODE    = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_FALLBACK_CODE = 2'd2;

	// Preset palette: black, red, blue, yellow, white, green, grey, white
	localparam logic [RGB_W-1:0] PRESET_COLORS [PRESET_N] = '{
		24'h000000, 24'hFF0000, 24'h0000FF, 24'hFFFF00,
		24'hFFFFFF, 24'h00FF00, 24'h808080, 24'hFFFFFF
	};

	typedef struct packed {
		logic       op;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} psa_req_t;

	typedef struct packed {
		logic [CIDX_W-1:0]  color_index;
		logic [STAT_W-1:0]  status;
		logic [SLOTS_W-1:0] slots_in_use;
	} psa_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} psa_state_t;

endpackage

>>> rtl/psa_store.sv
module psa_store import psa_pkg::*; #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  logic [RGB_W-1:0]               wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	output logic [RGB_W-1:0]               rd_data
);

	logic [RGB_W-1:0] mem [TABLE_DEPTH];
	logic [RGB_W-1:0] mem_rd_s1;
	logic [RGB_W-1:0] preset_rd_s1;
	logic             preset_sel_s1;

	// Write one allocated entry; preset slots are never written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one entry per cycle, overlaying the fixed presets on the low slots
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_s1     <= mem[rd_addr];
			preset_rd_s1  <= PRESET_COLORS[rd_addr[2:0]];
			preset_sel_s1 <= ((rd_addr >> 3) == '0);
		end
	end

	assign rd_data = preset_sel_s1 ? preset_rd_s1 : mem_rd_s1;

endmodule

>>> rtl/palette_slot_allocator_unit.sv
// Palette slot allocator. A request beat with a color returns a palette index: white or
// black gives white_code; otherwise the used slots are scanned in order, one entry per
// cycle through a single 24-bit compare fed by the palette memory's read port, and the
// first match is returned. Without a match the color is stored in the next free slot
// while the count is below min(table_limit, TABLE_DEPTH), else fallback_code is returned.
// A restart beat (op 0) sets the count back to the eight presets. A scanning request
// presents its result once the scan reaches a match or passes the last used slot;
// restart and black/white beats go straight to S_FINISH. One beat is in work at a
// time and req is stalled until the cycle after its result is loaded, so a beat also
// holds the block while the previous result waits on rsp_stall. Presets live in
// constant logic, so no clearing pass follows reset.
module palette_slot_allocator_unit import psa_pkg::*; #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  psa_req_t            req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output psa_rsp_t            rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int OIX_W = (IDX_W > CIDX_W) ? IDX_W : CIDX_W;

	psa_state_t state_q, state_d;

	logic [LIMIT_W-1:0] table_limit_q;
	logic [CIDX_W-1:0]  white_code_q;
	logic [CIDX_W-1:0]  fallback_code_q;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   addr_q;
	logic [CNT_W-1:0]   cnt_inc;
	logic               pend_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [RGB_W-1:0]   rgb_q;
	psa_rsp_t           res_q;
	psa_rsp_t           rsp_q;
	logic               rsp_valid_q;

	logic               acc_req;
	logic [RGB_W-1:0]   req_rgb;
	logic               req_bw;
	logic               issue;
	logic               match;
	logic               scan_end;
	logic               can_alloc;
	logic               mem_wr;
	logic               slot_free;
	logic [RGB_W-1:0]   rd_data;

	logic [LIM_W-1:0]   lim_ext;
	logic [LIM_W-1:0]   eff_limit;
	logic [LIM_W-1:0]   cnt_ext;
	logic [LIM_W-1:0]   inc_ext;
	logic [OIX_W-1:0]   hit_ext;

	// Decode the incoming beat
	assign acc_req = req_valid && !req_stall;
	assign req_rgb = {req.red, req.green, req.blue};
	assign req_bw  = (req_rgb == {RGB_W{1'b1}}) || (req_rgb == '0);

	// Scan control: issue one read per cycle, compare the data in the cycle after
	assign issue     = (state_q == S_SCAN) && (addr_q < count_q);
	assign match     = pend_s1 && (rd_data == rgb_q);
	assign scan_end  = (state_q == S_SCAN) && !pend_s1 && !issue;

	// Clamp the limit to the table depth and check for a free slot
	assign lim_ext   = LIM_W'(table_limit_q);
	assign eff_limit = (lim_ext > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : lim_ext;
	assign cnt_ext   = LIM_W'(count_q);
	assign cnt_inc   = count_q + CNT_W'(1);
	assign inc_ext   = LIM_W'(cnt_inc);
	assign hit_ext   = OIX_W'(idx_s1);
	assign can_alloc = cnt_ext < eff_limit;
	assign mem_wr    = scan_end && can_alloc;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	psa_store #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (rgb_q),
		.rd_en   (issue),
		.rd_addr (addr_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc_req) begin
					if (req.op == OP_REQUEST && !req_bw) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				if (match || scan_end) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		req_stall = (state_q != S_IDLE);
		rsp_valid = rsp_valid_q;
		rsp       = rsp_q;
		cfg_ready = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_limit_q   <= 9'd256;
			white_code_q    <= 8'd4;
			fallback_code_q <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TABLE_LIMIT:   table_limit_q   <= cfg_data[LIMIT_W-1:0];
				CFG_WHITE_CODE:    white_code_q    <= cfg_data[CIDX_W-1:0];
				CFG_FALLBACK_CODE: fallback_code_q <= cfg_data[CIDX_W-1:0];
				default: ;
			endcase
		end
	end

	// Slot count and scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(PRESET_N);
			addr_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (acc_req && req.op == OP_RESTART) begin
				count_q <= CNT_W'(PRESET_N);
			end else if (mem_wr) begin
				count_q <= cnt_inc;
			end
			if (acc_req) begin
				addr_q <= '0;
			end else if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
		end
	end

	// Hold the color and the slot number of the entry in flight
	always_ff @(posedge clk) begin
		if (acc_req) begin
			rgb_q <= req_rgb;
		end
		idx_s1 <= addr_q[IDX_W-1:0];
	end

	// Form the result of the beat
	always_ff @(posedge clk) begin
		if (acc_req) begin
			if (req.op == OP_RESTART) begin
				res_q.color_index  <= '0;
				res_q.status       <= STAT_RESTARTED;
				res_q.slots_in_use <= SLOTS_W'(PRESET_N);
			end else begin
				res_q.color_index  <= white_code_q;
				res_q.status       <= STAT_BW;
				res_q.slots_in_use <= cnt_ext[SLOTS_W-1:0];
			end
		end else if (match) begin
			res_q.color_index  <= hit_ext[CIDX_W-1:0];
			res_q.status       <= STAT_MATCHED;
			res_q.slots_in_use <= cnt_ext[SLOTS_W-1:0];
		end else if (mem_wr) begin
			res_q.color_index  <= cnt_ext[CIDX_W-1:0];
			res_q.status       <= STAT_ALLOCATED;
			res_q.slots_in_use <= inc_ext[SLOTS_W-1:0];
		end else if (scan_end) begin
			res_q.color_index  <= fallback_code_q;
			res_q.status       <= STAT_FULL;
			res_q.slots_in_use <= cnt_ext[SLOTS_W-1:0];
		end
	end

	// Output register: load when the slot is free, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && slot_free) begin
			rsp_q <= res_q;
		end
	end

	`include "palette_slot_allocator_unit_assert.svh"

	`PSA_ASSERT_NEXT(a_busy_after_accept, acc_req, req_stall, "input not stalled after accept")
	`PSA_ASSERT_SAME(a_count_range, 1'b1,
		count_q >= CNT_W'(PRESET_N) && cnt_ext <= LIM_W'(TABLE_DEPTH), "slot count out of range")
	`PSA_ASSERT_SAME(a_alloc_below_limit, mem_wr,
		cnt_ext < eff_limit && count_q >= CNT_W'(PRESET_N), "allocation past limit or into a preset")
	`PSA_ASSERT_NEXT(a_result_loaded, state_q == S_FINISH && slot_free,
		rsp_valid_q && state_q == S_IDLE, "finished result not presented")

endmodule
